// ===== rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam logic [15:0] REPL_CHAR      = 16'hFFFD;
    localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST     = 21'h00D800;
    localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
    localparam logic [20:0] SUPPL_BASE     = 21'h010000;
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

    localparam logic [2:0] SEQ_LEN_TWO   = 3'd2;
    localparam logic [2:0] SEQ_LEN_THREE = 3'd3;
    localparam logic [2:0] SEQ_LEN_FOUR  = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [15:0] unit;
        logic        present;
        logic        status;
        logic [15:0] total;
    } slot_t;

    // One accepted byte yields at most two results.
    typedef struct packed {
        slot_t       s0;
        slot_t       s1;
        logic [1:0]  count;
        logic        done;
    } run_t;

    function automatic run_t push_slot(run_t d, logic [15:0] u, logic p, logic s,
                                       logic [15:0] t);
        slot_t sl;
        run_t  r;
        sl.unit    = u;
        sl.present = p;
        sl.status  = s;
        sl.total   = t;
        r = d;
        if (d.count == 2'd0)
        begin
            r.s0    = sl;
            r.count = 2'd1;
        end
        else if (d.count == 2'd1)
        begin
            r.s1    = sl;
            r.count = 2'd2;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/u8u16_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front
    import u8u16_pkg::*;
#(
    parameter logic [31:0] MAX_UNITS = 32'd65535
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       lossy,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       byte_present,
    input  wire logic       string_end,
    input  wire logic       q_full,
    output logic            q_push,
    output run_t            q_run
);

    localparam logic [15:0] UNIT_LIMIT =
        (MAX_UNITS < 32'd65535) ? MAX_UNITS[15:0] : 16'hFFFF;

    logic [20:0] pp_reg, pp_next;
    logic [1:0]  pend_reg, pend_next;
    logic [2:0]  len_reg, len_next;
    logic        halt_reg, halt_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        accept;
    run_t        run;

    function automatic logic [15:0] bump(logic [15:0] c);
        return (c < UNIT_LIMIT) ? c + 16'd1 : c;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (run.count != 2'd0);
    assign q_run    = run;

    always_comb
    begin
        logic [20:0] cp;
        logic [20:0] min_cp;
        logic        fail;
        logic        do_lead;
        logic [19:0] off;

        run       = '0;
        pp_next   = pp_reg;
        pend_next = pend_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        halt_next = halt_reg;
        fail      = 1'b0;
        do_lead   = 1'b0;
        cp        = '0;
        min_cp    = '0;
        off       = '0;

        if (halt_reg)
        begin
            if (string_end)
            begin
                halt_next = 1'b0;
                pp_next   = '0;
                pend_next = '0;
                len_next  = '0;
                cnt_next  = '0;
            end
        end
        else
        begin
            if (byte_present)
            begin
                if (pend_reg != 2'd0)
                begin
                    if (in_byte[7:6] == 2'b10)
                    begin
                        pp_next   = {pp_reg[14:0], in_byte[5:0]};
                        pend_next = pend_reg - 2'd1;
                        if (pend_next == 2'd0)
                        begin
                            cp = pp_next;
                            if (len_reg == SEQ_LEN_TWO)
                                min_cp = MIN_TWO_BYTE;
                            else if (len_reg == SEQ_LEN_THREE)
                                min_cp = MIN_THREE_BYTE;
                            else
                                min_cp = SUPPL_BASE;
                            if ((cp >= SURR_FIRST && cp <= SURR_LAST) || cp > MAX_POINT ||
                                (cp < min_cp && !lossy))
                            begin
                                if (lossy)
                                begin
                                    cnt_next = bump(cnt_next);
                                    run = push_slot(run, REPL_CHAR, 1'b1, 1'b0, cnt_next);
                                end
                                else
                                begin
                                    run  = push_slot(run, 16'h0000, 1'b0, 1'b1, cnt_next);
                                    fail = 1'b1;
                                end
                            end
                            else if (cp < SUPPL_BASE)
                            begin
                                cnt_next = bump(cnt_next);
                                run = push_slot(run, cp[15:0], 1'b1, 1'b0, cnt_next);
                            end
                            else
                            begin
                                off = 20'(cp - SUPPL_BASE);
                                cnt_next = bump(cnt_next);
                                run = push_slot(run, HIGH_SURR_BASE | {6'd0, off[19:10]},
                                                1'b1, 1'b0, cnt_next);
                                cnt_next = bump(cnt_next);
                                run = push_slot(run, LOW_SURR_BASE | {6'd0, off[9:0]},
                                                1'b1, 1'b0, cnt_next);
                            end
                        end
                    end
                    else
                    begin
                        // A broken sequence; in lossy mode the byte starts over as a lead.
                        pend_next = 2'd0;
                        if (lossy)
                        begin
                            cnt_next = bump(cnt_next);
                            run = push_slot(run, REPL_CHAR, 1'b1, 1'b0, cnt_next);
                            do_lead = 1'b1;
                        end
                        else
                        begin
                            run  = push_slot(run, 16'h0000, 1'b0, 1'b1, cnt_next);
                            fail = 1'b1;
                        end
                    end
                end
                else
                begin
                    do_lead = 1'b1;
                end

                if (do_lead)
                begin
                    if (in_byte[7] == 1'b0)
                    begin
                        cnt_next = bump(cnt_next);
                        run = push_slot(run, {8'd0, in_byte}, 1'b1, 1'b0, cnt_next);
                    end
                    else if (in_byte[7:5] == 3'b110)
                    begin
                        pp_next   = {16'd0, in_byte[4:0]};
                        pend_next = 2'd1;
                        len_next  = SEQ_LEN_TWO;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        pp_next   = {17'd0, in_byte[3:0]};
                        pend_next = 2'd2;
                        len_next  = SEQ_LEN_THREE;
                    end
                    else if (in_byte[7:3] == 5'b11110)
                    begin
                        pp_next   = {18'd0, in_byte[2:0]};
                        pend_next = 2'd3;
                        len_next  = SEQ_LEN_FOUR;
                    end
                    else if (lossy)
                    begin
                        cnt_next = bump(cnt_next);
                        run = push_slot(run, REPL_CHAR, 1'b1, 1'b0, cnt_next);
                    end
                    else
                    begin
                        run  = push_slot(run, 16'h0000, 1'b0, 1'b1, cnt_next);
                        fail = 1'b1;
                    end
                end
            end

            // A string that ends inside a sequence is truncated.
            if (!fail && string_end && pend_next != 2'd0)
            begin
                pend_next = 2'd0;
                if (lossy)
                begin
                    cnt_next = bump(cnt_next);
                    run = push_slot(run, REPL_CHAR, 1'b1, 1'b0, cnt_next);
                end
                else
                begin
                    run  = push_slot(run, 16'h0000, 1'b0, 1'b1, cnt_next);
                    fail = 1'b1;
                end
            end

            if (fail || string_end)
            begin
                if (run.count == 2'd0)
                    run = push_slot(run, 16'h0000, 1'b0, 1'b0, cnt_next);
                run.done  = 1'b1;
                pp_next   = '0;
                pend_next = '0;
                len_next  = '0;
                cnt_next  = '0;
                if (fail && !string_end)
                    halt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg   <= '0;
            pend_reg <= '0;
            len_reg  <= '0;
            halt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            pp_reg   <= pp_next;
            pend_reg <= pend_next;
            len_reg  <= len_next;
            halt_reg <= halt_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8u16_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue
    import u8u16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t push_run,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output run_t      head
);

    run_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8u16_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_empty,
    input  wire run_t  q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [15:0] code_unit,
    output logic       unit_present,
    output logic       string_done,
    output logic       status,
    output logic [15:0] unit_total,
    output logic       last_of_run
);

    logic  idx_reg;
    logic  last;
    logic  take;
    slot_t cur;

    assign cur  = idx_reg ? q_head.s1 : q_head.s0;
    assign last = idx_reg || (q_head.count == 2'd1);
    assign take = out_valid && out_ready;

    assign out_valid    = !q_empty;
    assign code_unit    = cur.unit;
    assign unit_present = cur.present;
    assign status       = cur.status;
    assign unit_total   = cur.total;
    assign string_done  = q_head.done && last;
    assign last_of_run  = last;
    assign q_pop        = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 1'b0;
        else if (take)
            idx_reg <= !last;
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_to_utf16_transcoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to UTF-16 transcoder. One byte item is accepted per clock cycle while the
// queue is not full; it is decoded in the cycle it is accepted and its results (one
// or two code units, or a status-only item) go into a four-entry run queue. Results
// are registered there and leave one per cycle while out_ready is high; a byte that
// gives a surrogate pair or two replacement characters makes two output items; the
// queue lets the input keep going meanwhile. lossy_mode is written through the cfg
// channel, which is always ready, and should only change while the block is idle.

module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
#(
    parameter logic [31:0] MAX_UNITS = 32'd65535
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        lossy_mode,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        byte_present,
    input  wire logic        string_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             unit_present,
    output logic             string_done,
    output logic             status,
    output logic [15:0]      unit_total,
    output logic             last_of_run
);

    logic lossy_reg;
    logic q_push, q_pop, q_full, q_empty;
    run_t q_run, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lossy_reg <= 1'b0;
        else if (cfg_valid)
            lossy_reg <= lossy_mode;
    end

    u8u16_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .lossy        (lossy_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .byte_present (byte_present),
        .string_end   (string_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_run        (q_run)
    );

    u8u16_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_run (q_run),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    u8u16_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_unit    (code_unit),
        .unit_present (unit_present),
        .string_done  (string_done),
        .status       (status),
        .unit_total   (unit_total),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/u8u16_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8u16_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        lossy_mode,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        byte_present,
    input  wire logic        string_end,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        unit_present,
    input  wire logic        string_done,
    input  wire logic        status,
    input  wire logic [15:0] unit_total,
    input  wire logic        last_of_run
);

    // A stalled result item must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(unit_total))
        else $error("output item changed while stalled");

    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unit_present |-> code_unit == 16'h0000)
        else $error("status-only item carries a code unit");

    // An invalid status only appears on the item that closes a string.
    a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> string_done && last_of_run && !unit_present)
        else $error("invalid status on a non-final item");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> last_of_run)
        else $error("string end not on the last item of its run");

    a_unit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unit_present |-> unit_total != 16'h0000)
        else $error("code unit emitted with zero unit total");

endmodule

bind utf8_to_utf16_transcoder_top u8u16_checker u_checker (.*);

`default_nettype wire

// ===== test/utf16_unit_checker.sv =====
`timescale 1ns / 1ps

module utf16_unit_checker
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        lossy_mode,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        byte_present,
    input  wire logic        string_end,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        unit_present,
    input  wire logic        string_done,
    input  wire logic        status,
    input  wire logic [15:0] unit_total,
    input  wire logic        last_of_run,
    output int               mismatch_count,
    output int               units_outstanding
);

    localparam logic [15:0] UNIT_LIMIT     = 16'hFFFF;
    localparam logic        STATUS_OK      = 1'b0;
    localparam logic        STATUS_INVALID = 1'b1;
    localparam int          REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [15:0] unit;
        logic        present;
        logic        done;
        logic        stat;
        logic [15:0] total;
        logic        last;
    } unit_item_t;

    logic        lossy        = 1'b0;
    logic [20:0] point_acc    = '0;
    logic [1:0]  cont_left    = '0;
    logic [2:0]  seq_len      = '0;
    logic        halted       = 1'b0;
    logic [15:0] units_so_far = '0;
    unit_item_t  step_items[$];
    unit_item_t  expected_units[$];

    function automatic void add_item(logic [15:0] u, logic p, logic s);
        unit_item_t it;
        it.unit    = p ? u : 16'h0000;
        it.present = p;
        it.done    = 1'b0;
        it.stat    = s;
        it.total   = units_so_far;
        it.last    = 1'b0;
        if (step_items.size() < 4)
            step_items.push_back(it);
    endfunction

    function automatic void emit_unit(logic [15:0] u);
        if (units_so_far < UNIT_LIMIT)
            units_so_far = units_so_far + 16'd1;
        add_item(u, 1'b1, STATUS_OK);
    endfunction

    function automatic void emit_point(logic [20:0] cp);
        logic [20:0] offs;
        if (cp <= 21'h00FFFF)
            emit_unit(cp[15:0]);
        else
        begin
            offs = cp - SUPPL_BASE;
            emit_unit(HIGH_SURR_BASE | {6'd0, offs[19:10]});
            emit_unit(LOW_SURR_BASE | {6'd0, offs[9:0]});
        end
    endfunction

    // Returns 1 when the error ends the string, which only happens in strict mode.
    function automatic logic flag_error();
        if (lossy)
        begin
            emit_unit(REPL_CHAR);
            return 1'b0;
        end
        add_item(16'h0000, 1'b0, STATUS_INVALID);
        return 1'b1;
    endfunction

    function automatic logic open_sequence(logic [7:0] b);
        if (b[7] == 1'b0)
            emit_unit({8'h00, b});
        else if (b[7:5] == 3'b110)
        begin
            point_acc = {16'd0, b[4:0]};
            cont_left = 2'd1;
            seq_len   = SEQ_LEN_TWO;
        end
        else if (b[7:4] == 4'b1110)
        begin
            point_acc = {17'd0, b[3:0]};
            cont_left = 2'd2;
            seq_len   = SEQ_LEN_THREE;
        end
        else if (b[7:3] == 5'b11110)
        begin
            point_acc = {18'd0, b[2:0]};
            cont_left = 2'd3;
            seq_len   = SEQ_LEN_FOUR;
        end
        else
            return flag_error();
        return 1'b0;
    endfunction

    function automatic logic close_sequence();
        logic [20:0] floor_val;
        if (seq_len == SEQ_LEN_TWO)
            floor_val = MIN_TWO_BYTE;
        else if (seq_len == SEQ_LEN_THREE)
            floor_val = MIN_THREE_BYTE;
        else
            floor_val = SUPPL_BASE;
        if ((point_acc >= SURR_FIRST && point_acc <= SURR_LAST) || point_acc > MAX_POINT)
            return flag_error();
        // Overlong forms are only an error in strict mode; lossy mode decodes them.
        if (point_acc < floor_val && !lossy)
            return flag_error();
        emit_point(point_acc);
        return 1'b0;
    endfunction

    function automatic void clear_string();
        point_acc    = '0;
        cont_left    = '0;
        seq_len      = '0;
        units_so_far = '0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic present, logic ends);
        logic       stop;
        int         n;
        unit_item_t it;
        stop = 1'b0;
        step_items.delete();
        if (halted)
        begin
            if (ends)
            begin
                halted = 1'b0;
                clear_string();
            end
            return;
        end
        if (present)
        begin
            if (cont_left != 2'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    point_acc = {point_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                        stop = close_sequence();
                end
                else
                begin
                    // In lossy mode the byte that broke the sequence is taken again as a new lead.
                    cont_left = 2'd0;
                    stop = flag_error();
                    if (!stop)
                        stop = open_sequence(b);
                end
            end
            else
                stop = open_sequence(b);
        end
        if (!stop && ends && cont_left != 2'd0)
        begin
            cont_left = 2'd0;
            stop = flag_error();
        end
        if (stop || ends)
        begin
            if (step_items.size() == 0)
                add_item(16'h0000, 1'b0, STATUS_OK);
            if (stop && !ends)
                halted = 1'b1;
        end
        n = step_items.size();
        for (int k = 0; k < n; k++)
        begin
            it = step_items[k];
            it.done = (stop || ends) && (k == n - 1);
            it.last = (k == n - 1);
            expected_units.push_back(it);
        end
        if (stop || ends)
            clear_string();
    endfunction

    function automatic void note_mismatch(string what, unit_item_t want, unit_item_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected unit %h present %b done %b status %b total %0d last %b",
                     $time, what, want.unit, want.present, want.done, want.stat,
                     want.total, want.last);
            $display("%0t: %s: actual   unit %h present %b done %b status %b total %0d last %b",
                     $time, what, got.unit, got.present, got.done, got.stat,
                     got.total, got.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        unit_item_t want;
        unit_item_t got;
        if (!rst_n)
        begin
            lossy  = 1'b0;
            halted = 1'b0;
            clear_string();
            expected_units.delete();
            units_outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lossy = lossy_mode;
            if (in_valid && in_ready)
                decode_byte(in_byte, byte_present, string_end);
            if (out_valid && out_ready)
            begin
                got = {code_unit, unit_present, string_done, status, unit_total, last_of_run};
                if (expected_units.size() == 0)
                    note_mismatch("item with none expected", '0, got);
                else
                begin
                    want = expected_units.pop_front();
                    if (got !== want)
                        note_mismatch("item mismatch", want, got);
                end
            end
            units_outstanding = expected_units.size();
        end
    end

endmodule

// ===== test/utf8_to_utf16_transcoder_top_test.sv =====
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top_test;

    localparam logic MODE_STRICT  = 1'b0;
    localparam logic MODE_LOSSY   = 1'b1;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   HOLD_CYCLES  = 200;
    localparam int   NOISE_PCT    = 15;

    typedef enum int {
        FLAW_NONE,
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_RANGE,
        FLAW_BAD_LEAD,
        FLAW_TRUNCATE,
        FLAW_BROKEN
    } flaw_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        lossy_mode   = 1'b0;
    logic        in_valid     = 1'b0;
    logic [7:0]  in_byte      = 8'h00;
    logic        byte_present = 1'b0;
    logic        string_end   = 1'b0;
    logic        out_ready    = 1'b0;
    logic        cfg_ready;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] code_unit;
    logic        unit_present;
    logic        string_done;
    logic        status;
    logic [15:0] unit_total;
    logic        last_of_run;

    int          mismatch_count;
    int          units_outstanding;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    logic        hold_request  = 1'b0;
    logic        hold_seen     = 1'b0;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    logic [7:0]  string_bytes[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_to_utf16_transcoder_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .lossy_mode   (lossy_mode),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .byte_present (byte_present),
        .string_end   (string_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code_unit    (code_unit),
        .unit_present (unit_present),
        .string_done  (string_done),
        .status       (status),
        .unit_total   (unit_total),
        .last_of_run  (last_of_run)
    );

    utf16_unit_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .lossy_mode        (lossy_mode),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_byte           (in_byte),
        .byte_present      (byte_present),
        .string_end        (string_end),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .code_unit         (code_unit),
        .unit_present      (unit_present),
        .string_done       (string_done),
        .status            (status),
        .unit_total        (unit_total),
        .last_of_run       (last_of_run),
        .mismatch_count    (mismatch_count),
        .units_outstanding (units_outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        if (!hold_request)
            hold_seen <= 1'b0;
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic ends);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        byte_present <= present;
        string_end   <= ends;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (units_outstanding != 0)
            @(negedge clk);
        // Bytes that cause no unit may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        drain_results();
        cfg_valid  <= 1'b1;
        lossy_mode <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Appends one code point to string_bytes, sometimes with a deliberate flaw.
    function automatic void add_point(int noise_pct);
        logic [20:0] cp;
        logic [7:0]  enc[4];
        logic [7:0]  junk;
        int          len;
        flaw_t       flaw;
        len  = $urandom_range(1, 4);
        flaw = FLAW_NONE;
        if ($urandom_range(0, 99) < noise_pct)
            flaw = flaw_t'($urandom_range(FLAW_OVERLONG, FLAW_BROKEN));
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: cp = 21'($urandom_range('h800, 'hFFFF));
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        if (flaw == FLAW_OVERLONG)
        begin
            case (len)
                2: cp = 21'($urandom_range(0, 'h7F));
                3: cp = 21'($urandom_range(0, 'h7FF));
                4: cp = 21'($urandom_range(0, 'hFFFF));
                default: cp = cp;
            endcase
        end
        else if (flaw == FLAW_SURROGATE)
        begin
            len = 3;
            cp  = 21'($urandom_range('hD800, 'hDFFF));
        end
        else if (flaw == FLAW_RANGE)
        begin
            len = 4;
            cp  = 21'($urandom_range('h110000, 'h1FFFFF));
        end
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        if (flaw == FLAW_BAD_LEAD)
        begin
            if ($urandom_range(0, 1) == 0)
                string_bytes.push_back(8'($urandom_range('h80, 'hBF)));
            else
                string_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
        end
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1 && len > 1 && flaw == FLAW_TRUNCATE)
                break;
            if (i == len - 1 && len > 1 && flaw == FLAW_BROKEN)
            begin
                junk = 8'($urandom_range(0, 255));
                if (junk[7:6] == 2'b10)
                    junk[6] = 1'b1;
                string_bytes.push_back(junk);
            end
            else
                string_bytes.push_back(enc[i]);
        end
    endfunction

    task automatic send_string(input int n_points, input int noise_pct, output int sent);
        logic end_on_byte;
        int   n;
        string_bytes.delete();
        for (int i = 0; i < n_points; i++)
            add_point(noise_pct);
        end_on_byte = 1'($urandom_range(0, 1));
        n = string_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            // An idle item now and then; the block should ignore it.
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(string_bytes[k], 1'b1, end_on_byte && k == n - 1);
        end
        sent = n;
        if (!end_on_byte)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent = n + 1;
        end
    endtask

    task automatic run_phase(input logic mode, input int idle_pct, input int stall,
                             input int target);
        int count;
        int sent;
        write_mode(mode);
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        count = 0;
        while (count < target)
        begin
            send_string($urandom_range(1, 4), NOISE_PCT, sent);
            count += sent;
        end
    endtask

    initial
    begin
        int sent;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Strict mode: well-formed strings, then errors that halt the string.
        write_mode(MODE_STRICT);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'hA9, 1'b1, 1'b0);
        send_item(8'hF0, 1'b1, 1'b0);
        send_item(8'h9F, 1'b1, 1'b0);
        send_item(8'h98, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hC0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);

        // Lossy mode: overlong, broken, surrogate, out of range, truncated, bad lead.
        write_mode(MODE_LOSSY);
        send_item(8'hC0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'hED, 1'b1, 1'b0);
        send_item(8'hA0, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hF4, 1'b1, 1'b0);
        send_item(8'h90, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);

        run_phase(MODE_LOSSY, 0, 0, 10);
        run_phase(MODE_STRICT, 46, 0, 10);
        run_phase(MODE_LOSSY, 0, 46, 10);
        run_phase(MODE_STRICT, 7, 7, 10);

        // Long output hold-off while strings of random code points keep the input busy.
        write_mode(MODE_LOSSY);
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_request <= 1'b1;
        send_string(4, 0, sent);
        send_string(4, 0, sent);
        hold_request <= 1'b0;

        drain_results();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
